### rtl/mps_pkg.sv
// Shared types, constants and helper functions for the motion profile sampler.
package mps_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  // Wide enough for x0*2^(2F+1) + v0*r*2^(F+1) + a0*r*r with signed margin.
  localparam int unsigned ACC_W     = 2 * FRAC_BITS + 66;
  localparam int unsigned MUL_W     = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * MUL_W;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_PAST   = 3'd3,
    STAT_BEFORE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL_AT,
    ST_VEL,
    ST_POS0,
    ST_POS1,
    ST_POS2,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_FRAC1,
    SH_WORD
  } shift_sel_e;

  typedef struct packed {
    logic [DATA_W-1:0] duration;
    logic [DATA_W-1:0] accel;
    logic [DATA_W-1:0] velocity;
    logic [DATA_W-1:0] position;
  } seg_rec_t;

  typedef struct packed {
    logic             mul_en;
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
    acc_op_e          acc_op;
    shift_sel_e       shift_sel;
    logic [ACC_W-1:0] acc_init;
  } mac_ctrl_t;

  // Saturate an already shifted accumulator value to 32 bits.
  function automatic logic [DATA_W-1:0] sat32(logic [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    logic [DATA_W-1:0]     res;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      res = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Negate with saturation: the most negative value maps to the most positive.
  function automatic logic [DATA_W-1:0] neg_sat(logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] res;
    if (x == {1'b1, {(DATA_W-1){1'b0}}}) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res = DATA_W'(~x + DATA_W'(1));
    end
    return res;
  endfunction

endpackage

### rtl/mps_seg_mem.sv
// Segment record memory: one write port, one registered read port.
module mps_seg_mem import mps_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  seg_rec_t      wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output seg_rec_t      rd_data_o
);

  seg_rec_t mem_q [DEPTH];
  seg_rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/mps_mac.sv
// Shared multiply-accumulate unit: one registered 33x33 multiplier and a wide accumulator.
module mps_mac import mps_pkg::*; (
  input  logic              clk_i,
  input  mac_ctrl_t         ctrl_i,
  output logic [PROD_W-1:0] prod_o,
  output logic [ACC_W-1:0]  acc_o
);

  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  addend;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'($signed(ctrl_i.mul_a) * $signed(ctrl_i.mul_b));
    end
  end

  assign prod_ext = ACC_W'($signed(prod_q));

  always_comb begin
    unique case (ctrl_i.shift_sel)
      SH_NONE:  addend = prod_ext;
      SH_FRAC1: addend = prod_ext << (FRAC_BITS + 1);
      SH_WORD:  addend = prod_ext << DATA_W;
      default:  addend = prod_ext;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = ctrl_i.acc_init + addend;
      ACC_ADD:  acc_d = acc_q + addend;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

### rtl/motion_profile_sampler_top.sv
// Motion profile sampler: segment table, walk sequencer and evaluation control.
//
// Input stream (s_axis_*): tuser carries the mode (clear, append, query),
// tdata the segment fields and the query time. Each transfer gives exactly
// one result transfer on m_axis_*: position, velocity, acceleration in tdata
// and a status code in tuser.
// Clear and append finish in the accepting cycle; their result is offered
// the next cycle. A query reads the table through one registered memory
// port, one segment per cycle, then runs the evaluation, which passes its
// four products through the single shared multiplier.
// One item is in work at a time; s_axis_tready is high only while the
// sequencer is idle and the output register is empty or being emptied.
// A stalled receiver holds the result in the output register and blocks new
// input until it is taken.
// Reset empties the table, clears mirroring and drops any pending result.
// The mirror register is written through cfg_wr_en_i/cfg_wr_data_i; the
// user must write it only while idle, as the block itself does not enforce
// this.
module motion_profile_sampler_top import mps_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic         cfg_wr_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] seg_position, [63:32] seg_velocity, [95:64] seg_accel,
  // [127:96] seg_duration, [159:128] query_time
  input  logic [159:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] out_position, [63:32] out_velocity, [95:64] out_accel
  output logic [95:0]  m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]   m_axis_tuser_o
);

  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  state_e state_q, state_d;

  logic             mirror_q;
  logic [CNT_W-1:0] count_q;
  logic             out_vld_q;
  logic [DATA_W-1:0] out_pos_q, out_vel_q, out_acc_q;
  status_e          status_q, res_status_q;

  logic [DATA_W-1:0] r_q;
  logic              neg_q;
  logic              pend_q;
  logic [IDX_W-1:0]  rd_idx_q, cmp_idx_q;
  logic [DATA_W-1:0] r_eval_q;
  logic [DATA_W-1:0] x0_q, v0_q, a0_q;
  logic [63:0]       at_q;

  logic       in_xfer, out_xfer;
  logic [1:0] in_mode;
  seg_rec_t   in_rec;
  logic [DATA_W-1:0] in_qtime;
  logic       table_full;

  seg_rec_t  rd_data;
  logic      rd_en;
  logic      seg_hit, seg_last, walk_stop;
  mac_ctrl_t mac_ctrl;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [DATA_W-1:0] vel_sat, pos_sat;

  assign in_mode          = s_axis_tuser_i;
  assign in_rec.position  = s_axis_tdata_i[31:0];
  assign in_rec.velocity  = s_axis_tdata_i[63:32];
  assign in_rec.accel     = s_axis_tdata_i[95:64];
  assign in_rec.duration  = s_axis_tdata_i[127:96];
  assign in_qtime         = s_axis_tdata_i[159:128];

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer   = out_vld_q && m_axis_tready_i;
  assign table_full = (count_q >= CNT_W'(MAX_SEGMENTS));

  mps_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (IDX_W)
  ) u_seg_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer && (in_mode == MODE_APPEND) && !table_full),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (in_rec),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  mps_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Walk: compare the remaining time against the segment read last cycle.
  assign seg_hit   = neg_q || (r_q <= rd_data.duration);
  assign seg_last  = (CNT_W'(cmp_idx_q) == CNT_W'(count_q - CNT_W'(1)));
  assign walk_stop = pend_q && (seg_hit || seg_last);

  assign vel_sat = sat32(ACC_W'($signed(acc) >>> FRAC_BITS));
  assign pos_sat = sat32(ACC_W'($signed(acc) >>> (2 * FRAC_BITS + 1)));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_mode == MODE_QUERY) && (count_q != '0)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_stop) begin
          state_d = ST_MUL_AT;
        end
      end
      ST_MUL_AT: state_d = ST_VEL;
      ST_VEL:    state_d = ST_POS0;
      ST_POS0:   state_d = ST_POS1;
      ST_POS1:   state_d = ST_POS2;
      ST_POS2:   state_d = ST_FIN;
      ST_FIN:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready_o    = 1'b0;
    rd_en              = 1'b0;
    mac_ctrl.mul_en    = 1'b0;
    mac_ctrl.mul_a     = '0;
    mac_ctrl.mul_b     = {1'b0, r_eval_q};
    mac_ctrl.acc_op    = ACC_HOLD;
    mac_ctrl.shift_sel = SH_NONE;
    mac_ctrl.acc_init  = '0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = !out_vld_q || m_axis_tready_i;
      ST_WALK: rd_en = 1'b1;
      ST_MUL_AT: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.mul_a  = {a0_q[DATA_W-1], a0_q};
      end
      ST_VEL: begin
        // velocity = v0*2^F + a0*r, rounding half folded into the load
        mac_ctrl.acc_op   = ACC_LOAD;
        mac_ctrl.acc_init = (ACC_W'($signed(v0_q)) << FRAC_BITS)
                            | (ACC_W'(1) << (FRAC_BITS - 1));
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.mul_a    = {v0_q[DATA_W-1], v0_q};
      end
      ST_POS0: begin
        mac_ctrl.acc_op    = ACC_LOAD;
        mac_ctrl.shift_sel = SH_FRAC1;
        mac_ctrl.acc_init  = (ACC_W'($signed(x0_q)) << (2 * FRAC_BITS + 1))
                             | (ACC_W'(1) << (2 * FRAC_BITS));
        mac_ctrl.mul_en    = 1'b1;
        mac_ctrl.mul_a     = {1'b0, at_q[31:0]};
      end
      ST_POS1: begin
        mac_ctrl.acc_op = ACC_ADD;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.mul_a  = {at_q[63], at_q[63:32]};
      end
      ST_POS2: begin
        mac_ctrl.acc_op    = ACC_ADD;
        mac_ctrl.shift_sel = SH_WORD;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mirror_q  <= 1'b0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        mirror_q <= cfg_wr_data_i;
      end
      if (in_xfer && (in_mode == MODE_CLEAR)) begin
        count_q <= '0;
      end else if (in_xfer && (in_mode == MODE_APPEND) && !table_full) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (in_xfer && !((in_mode == MODE_QUERY) && (count_q != '0))) begin
        out_vld_q <= 1'b1;
      end else if (state_q == ST_FIN) begin
        out_vld_q <= 1'b1;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == ST_WALK) begin
        pend_q <= !walk_stop;
      end else begin
        pend_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_pos_q <= '0;
      out_vel_q <= '0;
      out_acc_q <= '0;
      r_q       <= in_qtime;
      neg_q     <= in_qtime[DATA_W-1];
      rd_idx_q  <= '0;
      if (in_mode == MODE_APPEND) begin
        status_q <= table_full ? STAT_FULL : STAT_OK;
      end else if ((in_mode == MODE_QUERY) && (count_q == '0)) begin
        status_q <= STAT_EMPTY;
      end else begin
        status_q <= STAT_OK;
      end
    end
    if (state_q == ST_WALK) begin
      rd_idx_q  <= rd_idx_q + IDX_W'(1);
      cmp_idx_q <= rd_idx_q;
      if (pend_q) begin
        r_q  <= r_q - rd_data.duration;
        x0_q <= rd_data.position;
        v0_q <= rd_data.velocity;
        a0_q <= rd_data.accel;
        if (neg_q) begin
          r_eval_q     <= '0;
          res_status_q <= STAT_BEFORE;
        end else if (seg_hit) begin
          r_eval_q     <= r_q;
          res_status_q <= STAT_OK;
        end else begin
          r_eval_q     <= rd_data.duration;
          res_status_q <= STAT_PAST;
        end
      end
    end
    if (state_q == ST_VEL) begin
      at_q <= prod[63:0];
    end
    if (state_q == ST_POS0) begin
      out_vel_q <= mirror_q ? neg_sat(vel_sat) : vel_sat;
    end
    if (state_q == ST_FIN) begin
      out_pos_q <= mirror_q ? neg_sat(pos_sat) : pos_sat;
      out_acc_q <= mirror_q ? neg_sat(a0_q) : a0_q;
      status_q  <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_acc_q, out_vel_q, out_pos_q};
  assign m_axis_tuser_o  = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && pend_q) |-> (CNT_W'(cmp_idx_q) < count_q))
    else $error("walk compared an entry outside the table");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!out_vld_q || m_axis_tready_i))
    else $error("input taken while a result is still held");

  a_query_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_mode == MODE_QUERY && count_q != '0) |=> !out_vld_q)
    else $error("query result offered before evaluation");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q == STAT_EMPTY) |-> (m_axis_tdata_o == '0))
    else $error("empty-table result carries data");
`endif

endmodule
